/* rtl/set_assoc_cache_tag_lru_assert.svh */
// Assertion macros for the cache tag store
`ifndef SET_ASSOC_CACHE_TAG_LRU_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LRU_ASSERT_SVH
`ifndef SYNTH
`define SACT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SACT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SACT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SACT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/sact_pkg.sv */
package sact_pkg;
    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_MARK   = 3'd2,
        OP_SNOOP  = 3'd3,
        OP_EVICT  = 3'd4,
        OP_INSERT = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } t_state;
endpackage

/* rtl/sact_front.sv */
module sact_front import sact_pkg::*; #(
    parameter int SET_BITS = 6,
    parameter int TAG_BITS = 20,
    parameter int QW       = 3 + 6 + 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [2:0]    i_op,
    input  logic [5:0]    i_set_index,
    input  logic [19:0]   i_tag,
    output logic          o_q_valid,
    output logic [QW-1:0] o_q_data,
    input  logic          i_q_take
);
    logic [SET_BITS-1:0] w_set;
    logic [TAG_BITS-1:0] w_tag;
    logic [1:0][QW-1:0]  r_q;
    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;
    logic                w_push_ok;

    // classify: wrap set index and trim tag
    assign w_set = SET_BITS'(i_set_index);
    assign w_tag = TAG_BITS'(i_tag);
    assign o_full = (r_cnt == 2'd2);
    assign w_push_ok = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data = r_q[0];

    always_comb begin
        n_cnt = r_cnt + 2'(w_push_ok) - 2'(i_q_take && o_q_valid);
    end

    // two-entry queue toward the back part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_q_take && o_q_valid) begin
            // advance the head; a beat arriving on a single entry lands at the head
            r_q[0] <= (w_push_ok && r_cnt == 2'd1) ? {i_op, w_set, w_tag} : r_q[1];
        end else if (w_push_ok) begin
            r_q[r_cnt[0]] <= {i_op, w_set, w_tag};
        end
    end
endmodule

/* rtl/sact_back.sv */
module sact_back import sact_pkg::*; #(
    parameter int SET_BITS = 6,
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20,
    parameter int QW       = 29
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  logic [QW-1:0] i_q_data,
    output logic          o_q_take,
    output logic          o_empty,
    input  logic          i_pop,
    output logic          o_hit,
    output logic          o_set_full,
    output logic          o_victim_dirty,
    output logic [19:0]   o_victim_tag
);
    localparam int SETS = 1 << SET_BITS;
    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EW = TAG_BITS + 2 + AW;
    localparam int LW = WAYS * EW;

    // tag/valid/dirty/age per set in one memory row
    logic [LW-1:0]          r_mem [SETS];
    logic                   r_init;
    logic [SET_BITS-1:0]    r_init_idx;
    t_state                 r_state, n_state;
    logic [LW-1:0]          r_row;
    logic [2:0]             r_op;
    logic [SET_BITS-1:0]    r_set;
    logic [TAG_BITS-1:0]    r_tag;
    logic                   r_out_v;
    logic                   r_hit, r_full, r_vd;
    logic [19:0]            r_vt;
    logic [TAG_BITS-1:0]    w_tags [WAYS];
    logic [WAYS-1:0]        w_dirty;
    logic [AW-1:0]          w_age [WAYS];
    logic [WAYS-1:0]        w_vld, n_vld;
    logic [LW-1:0]          w_row_new, w_init_row;
    logic                   w_hit, w_full, w_vd;
    logic [19:0]            w_vt;
    logic                   w_done;

    assign o_q_take = (r_state == ST_IDLE) && i_q_valid && r_init && !r_out_v;
    assign w_done = (r_state == ST_WRITE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (o_q_take) n_state = ST_READ;
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // reset row contents: all invalid and clean, ages equal way index
    always_comb begin
        w_init_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            w_init_row[w*EW +: AW] = AW'(w);
        end
    end

    // unpack row and apply operation
    always_comb begin
        logic [AW-1:0] old;
        logic          found;
        logic [AW-1:0] vic;
        for (int w = 0; w < WAYS; w++) begin
            w_age[w]   = r_row[w*EW +: AW];
            w_dirty[w] = r_row[w*EW+AW];
            w_vld[w]   = r_row[w*EW+AW+1];
            w_tags[w]  = r_row[w*EW+AW+2 +: TAG_BITS];
        end
        n_vld = w_vld;
        w_full = &w_vld;
        w_hit = 1'b0;
        w_vd = 1'b0;
        w_vt = '0;
        found = 1'b0;
        vic = '0;
        old = '0;
        case (r_op)
            OP_READ, OP_WRITE, OP_MARK: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (w_vld[w] && w_tags[w] == r_tag && !found) begin
                        if (r_op != OP_MARK) begin
                            found = 1'b1;
                            w_hit = 1'b1;
                        end
                        if (r_op != OP_READ) w_dirty[w] = 1'b1;
                        old = w_age[w];
                        for (int v = 0; v < WAYS; v++) begin
                            if (v != w && w_age[v] > old) w_age[v] = w_age[v] - AW'(1);
                        end
                        w_age[w] = AW'(WAYS - 1);
                    end
                end
            end
            OP_SNOOP: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (w_vld[w] && w_tags[w] == r_tag) n_vld[w] = 1'b0;
                end
            end
            OP_EVICT: begin
                for (int w = WAYS - 1; w >= 0; w--) begin
                    if (w_age[w] == '0) vic = AW'(w);
                end
                w_vd = w_dirty[vic];
                w_vt = 20'(w_tags[vic]);
                n_vld[vic] = 1'b0;
            end
            OP_INSERT: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (!w_vld[w] && !found) begin
                        found = 1'b1;
                        w_tags[w] = r_tag;
                        n_vld[w] = 1'b1;
                        w_dirty[w] = 1'b0;
                        old = w_age[w];
                        for (int v = 0; v < WAYS; v++) begin
                            if (v != w && w_age[v] > old) w_age[v] = w_age[v] - AW'(1);
                        end
                        w_age[w] = AW'(WAYS - 1);
                    end
                end
            end
            default: ;
        endcase
        for (int w = 0; w < WAYS; w++) begin
            w_row_new[w*EW +: AW] = w_age[w];
            w_row_new[w*EW+AW] = w_dirty[w];
            w_row_new[w*EW+AW+1] = n_vld[w];
            w_row_new[w*EW+AW+2 +: TAG_BITS] = w_tags[w];
        end
    end

    // sequencer, clearing pass and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_init     <= 1'b0;
            r_init_idx <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (!r_init) begin
                r_init_idx <= r_init_idx + SET_BITS'(1);
                if (r_init_idx == SET_BITS'(SETS - 1)) r_init <= 1'b1;
            end
            if (w_done) begin
                r_out_v <= 1'b1;
            end else if (i_pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_init) begin
            r_mem[r_init_idx] <= w_init_row;
        end else if (w_done) begin
            r_mem[r_set] <= w_row_new;
        end
        if (o_q_take) begin
            r_op  <= i_q_data[QW-1 -: 3];
            r_set <= i_q_data[TAG_BITS +: SET_BITS];
            r_tag <= i_q_data[TAG_BITS-1:0];
        end
        if (r_state == ST_IDLE) begin
            r_row <= r_mem[i_q_data[TAG_BITS +: SET_BITS]];
        end
        if (w_done) begin
            r_hit  <= w_hit;
            r_full <= w_full;
            r_vd   <= w_vd;
            r_vt   <= w_vt;
        end
    end

    assign o_empty = !r_out_v;
    assign o_hit = r_hit;
    assign o_set_full = r_full;
    assign o_victim_dirty = r_vd;
    assign o_victim_tag = r_vt;

    `include "set_assoc_cache_tag_lru_assert.svh"
    `SACT_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_q_take, r_state == ST_IDLE && !r_out_v)
    `SACT_ASSERT_NXT(a_done_result, i_clk, i_rst_n, w_done, r_out_v)
    `SACT_ASSERT_IMP(a_init_quiet, i_clk, i_rst_n, !r_init, r_state == ST_IDLE && !r_out_v)
endmodule

/* rtl/set_assoc_cache_tag_lru.sv */
// A request passes the front queue, then take with set read, a pass state, and update with
// write-back before its result is registered. The next take waits until the previous
// result has been popped, so the back part works on one request at a time.
// The front queue holds two requests so push continues while the back part works.
// Reset: synchronous active-low; after reset a clearing pass writes every set back to invalid,
// clean, zero tags and ages in way order while requests wait in the queue.
module set_assoc_cache_tag_lru import sact_pkg::*; #(
    parameter int SETS     = 64,
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [5:0]  i_set_index,
    input  logic [19:0] i_tag,
    output logic        empty,
    input  logic        pop,
    output logic        o_hit,
    output logic        o_set_full,
    output logic        o_victim_dirty,
    output logic [19:0] o_victim_tag
);
    localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int QW = 3 + SET_BITS + TAG_BITS;

    logic          w_qv, w_take;
    logic [QW-1:0] w_qd;

    sact_front #(.SET_BITS(SET_BITS), .TAG_BITS(TAG_BITS), .QW(QW)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_op, .i_set_index, .i_tag,
        .o_q_valid(w_qv), .o_q_data(w_qd), .i_q_take(w_take)
    );

    sact_back #(.SET_BITS(SET_BITS), .WAYS(WAYS), .TAG_BITS(TAG_BITS), .QW(QW)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_data(w_qd), .o_q_take(w_take),
        .o_empty(empty), .i_pop(pop), .o_hit, .o_set_full, .o_victim_dirty, .o_victim_tag
    );
endmodule

/* dv/set_assoc_cache_tag_lru_test.sv */
module set_assoc_cache_tag_lru_test;
    import sact_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS = 64;
    localparam int WAYS = 4;
    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  set_index;
        logic [19:0] tag;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic        set_full;
        logic        victim_dirty;
        logic [19:0] victim_tag;
    } t_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_op = '0;
    logic [5:0]  i_set_index = '0;
    logic [19:0] i_tag = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_hit;
    logic        o_set_full;
    logic        o_victim_dirty;
    logic [19:0] o_victim_tag;

    set_assoc_cache_tag_lru dut (.*);

    // Predictor state: one entry per line, set-major
    logic [19:0] line_tag [SETS*WAYS];
    logic        line_vld [SETS*WAYS];
    logic        line_dty [SETS*WAYS];
    logic [1:0]  line_age [SETS*WAYS];

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   beats_in = 0;
    int   beats_out = 0;
    int   evict_beats = 0;
    int   hit_beats = 0;
    bit   hold_push = 1'b0;
    int   push_gap = 0;
    int   pop_gap = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void touch_way(int base, int way);
        logic [1:0] prev;
        prev = line_age[base+way];
        for (int w = 0; w < WAYS; w++)
            if (w != way && line_age[base+w] > prev) line_age[base+w]--;
        line_age[base+way] = 2'(WAYS-1);
    endfunction

    function automatic t_rsp lookup_tags(t_req r);
        t_rsp o;
        int   base;
        int   victim;
        o = '0;
        base = int'(r.set_index) * WAYS;
        o.set_full = 1'b1;
        for (int w = 0; w < WAYS; w++)
            if (!line_vld[base+w]) o.set_full = 1'b0;
        case (r.op)
            OP_READ, OP_WRITE: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (line_vld[base+w] && line_tag[base+w] == r.tag) begin
                        if (r.op == OP_WRITE) line_dty[base+w] = 1'b1;
                        touch_way(base, w);
                        o.hit = 1'b1;
                        break;
                    end
                end
            end
            OP_MARK: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (line_vld[base+w] && line_tag[base+w] == r.tag) begin
                        line_dty[base+w] = 1'b1;
                        touch_way(base, w);
                    end
                end
            end
            OP_SNOOP: begin
                for (int w = 0; w < WAYS; w++)
                    if (line_vld[base+w] && line_tag[base+w] == r.tag) line_vld[base+w] = 1'b0;
            end
            OP_EVICT: begin
                victim = 0;
                for (int w = 0; w < WAYS; w++) begin
                    if (line_age[base+w] == 0) begin
                        victim = w;
                        break;
                    end
                end
                o.victim_dirty = line_dty[base+victim];
                o.victim_tag   = line_tag[base+victim];
                line_vld[base+victim] = 1'b0;
            end
            OP_INSERT: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (!line_vld[base+w]) begin
                        line_tag[base+w] = r.tag;
                        line_vld[base+w] = 1'b1;
                        line_dty[base+w] = 1'b0;
                        touch_way(base, w);
                        break;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Driver: present the next pending beat, advance on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                expected_rsps = {expected_rsps, lookup_tags(pending_reqs.pop_front())};
                beats_in++;
            end
            if (push && full) begin
                // hold current beat
            end else if (push_gap > 0) begin
                push_gap <= push_gap - 1;
                push <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_push) begin
                push        <= 1'b1;
                i_op        <= pending_reqs[0].op;
                i_set_index <= pending_reqs[0].set_index;
                i_tag       <= pending_reqs[0].tag;
                push_gap    <= pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: check each popped beat against the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                beats_out++;
                if (expected_rsps.size() == 0) begin
                    $error("result beat with no request outstanding");
                    errors++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want.victim_tag != '0 || want.victim_dirty) evict_beats++;
                    if (want.hit) hit_beats++;
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        errors++;
                    end
                    if (o_set_full !== want.set_full) begin
                        $error("set_full: expected %0d, got %0d", want.set_full, o_set_full);
                        errors++;
                    end
                    if (o_victim_dirty !== want.victim_dirty) begin
                        $error("victim_dirty: expected %0d, got %0d",
                               want.victim_dirty, o_victim_dirty);
                        errors++;
                    end
                    if (o_victim_tag !== want.victim_tag) begin
                        $error("victim_tag: expected %h, got %h", want.victim_tag, o_victim_tag);
                        errors++;
                    end
                end
            end
            if (pop_gap > 0) begin
                pop_gap <= pop_gap - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (pop && !empty) pop_gap <= pick_gap();
            end
        end
    end

    function automatic void queue_req(logic [2:0] op, logic [5:0] set_index, logic [19:0] tag);
        t_req r;
        r.op = op;
        r.set_index = set_index;
        r.tag = tag;
        pending_reqs = {pending_reqs, r};
    endfunction

    // Fill mostly sets 0 to 3 with a mix of ops on a small tag pool so hits and full sets occur
    task automatic queue_random(int count);
        logic [19:0] pool [8];
        logic [5:0]  hot;
        int          roll;
        for (int i = 0; i < 8; i++) pool[i] = 20'($urandom);
        for (int n = 0; n < count; n++) begin
            hot  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
            roll = $urandom_range(0, 99);
            if (roll < 25)      queue_req(OP_INSERT, hot, pool[$urandom_range(0, 7)]);
            else if (roll < 45) queue_req(OP_READ, hot, pool[$urandom_range(0, 7)]);
            else if (roll < 60) queue_req(OP_WRITE, hot, pool[$urandom_range(0, 7)]);
            else if (roll < 70) queue_req(OP_MARK, hot, pool[$urandom_range(0, 7)]);
            else if (roll < 78) queue_req(OP_SNOOP, hot, pool[$urandom_range(0, 7)]);
            else if (roll < 92) queue_req(OP_EVICT, hot, pool[$urandom_range(0, 7)]);
            else if (roll < 96) queue_req(3'($urandom_range(0, 7)), 6'($urandom), 20'($urandom));
            else                queue_req(($urandom_range(0, 1) != 0) ? OP_BAD6 : OP_BAD7,
                                          hot, 20'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < SETS*WAYS; i++) begin
            line_tag[i] = '0;
            line_vld[i] = 1'b0;
            line_dty[i] = 1'b0;
            line_age[i] = 2'(i % WAYS);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: evict on reset state, fill a set past full, hit, dirty, snoop, evict
        queue_req(OP_EVICT, 6'd63, 20'h00000);
        queue_req(OP_READ, 6'd0, 20'h00000);
        for (int w = 0; w < 5; w++) queue_req(OP_INSERT, 6'd0, 20'hFFFFF - 20'(w));
        queue_req(OP_READ, 6'd0, 20'hFFFFE);
        queue_req(OP_WRITE, 6'd0, 20'hFFFFF);
        queue_req(OP_WRITE, 6'd0, 20'h12345);
        queue_req(OP_MARK, 6'd0, 20'hFFFFD);
        queue_req(OP_EVICT, 6'd0, 20'h00000);
        queue_req(OP_EVICT, 6'd0, 20'h00000);
        queue_req(OP_SNOOP, 6'd0, 20'hFFFFC);
        queue_req(OP_INSERT, 6'd0, 20'hAAAAA);
        queue_req(OP_INSERT, 6'd0, 20'hAAAAA);
        queue_req(OP_MARK, 6'd0, 20'hAAAAA);
        queue_req(OP_EVICT, 6'd0, 20'h00000);
        queue_req(OP_BAD6, 6'd0, 20'h55555);
        queue_req(OP_BAD7, 6'd63, 20'hFFFFF);
        queue_req(OP_INSERT, 6'd63, 20'h00000);
        queue_req(OP_EVICT, 6'd63, 20'h00000);

        queue_random(450);
        wait (pending_reqs.size() == 0 && !push);
        // Hold the sender until the pipeline is fully drained
        hold_push = 1'b1;
        wait (expected_rsps.size() == 0);
        repeat (10) @(posedge i_clk);
        hold_push = 1'b0;
        queue_random(480);
        wait (pending_reqs.size() == 0 && !push);
        wait (expected_rsps.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests, %0d results, %0d hits, %0d nonzero victims",
                 beats_in, beats_out, hit_beats, evict_beats);
        if (errors == 0) begin
            $display("set_assoc_cache_tag_lru_test: done, clean");
        end else begin
            $display("set_assoc_cache_tag_lru_test: done, errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("set_assoc_cache_tag_lru_test: done, errors");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/sact_pkg.sv
rtl/sact_front.sv
rtl/sact_back.sv
rtl/set_assoc_cache_tag_lru.sv
dv/set_assoc_cache_tag_lru_test.sv
